// ----- sv/button_chord_touch_gesture_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the button chord and touch gesture tracker
// Defining ASSERT_OFF turns every check into an empty statement.
// ---------------------------------------------------------------------------
`ifndef BUTTON_CHORD_TOUCH_GESTURE_MACROS_SVH
`define BUTTON_CHORD_TOUCH_GESTURE_MACROS_SVH

`ifndef ASSERT_OFF

// ante in one cycle implies cons in the same cycle
`define BCTG_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bctg check failed: same-cycle implication");

// ante in one cycle implies cons in the next cycle
`define BCTG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bctg check failed: next-cycle implication");

`else

`define BCTG_ASSERT_IMPLY(lbl, ante, cons)
`define BCTG_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- sv/bctg_pkg.sv -----
// ---------------------------------------------------------------------------
// bctg_pkg
// Shared types and constants of the button chord and touch gesture tracker.
// ---------------------------------------------------------------------------
package bctg_pkg;

	// configuration register map
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	localparam int THR_W      = 12;
	localparam int HOLD_W     = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DRAG_THRESHOLD = 1'b0,
		CFG_HOLD_TIME_US   = 1'b1
	} cfg_idx_t;

	localparam logic [THR_W-1:0]  DRAG_THRESHOLD_RST = 12'd10;
	localparam logic [HOLD_W-1:0] HOLD_TIME_US_RST   = 32'd600000;

	// gesture codes
	localparam int GEST_W = 3;

	typedef enum logic [GEST_W-1:0] {
		GEST_NONE       = 3'd0,
		GEST_TAP        = 3'd1,
		GEST_DRAG_START = 3'd2,
		GEST_DRAG_MOVE  = 3'd3,
		GEST_DRAG_END   = 3'd4,
		GEST_CANCEL     = 3'd5
	} gesture_t;

endpackage

// ----- sv/bctg_if.sv -----
// ---------------------------------------------------------------------------
// bctg interfaces
// Valid/ready channels for samples, results and configuration writes.
// ---------------------------------------------------------------------------

// one input sample per item
interface bctg_in_if #(
	parameter int COORD_BITS = 12,
	parameter int TIME_BITS  = 32
) ();
	logic                  valid;
	logic                  ready;
	logic [TIME_BITS-1:0]  now_us;
	logic                  button_a;
	logic                  button_b;
	logic                  touching;
	logic [COORD_BITS-1:0] touch_x;
	logic [COORD_BITS-1:0] touch_y;
	logic                  consume_touch;

	modport source (
		output valid, now_us, button_a, button_b, touching, touch_x, touch_y, consume_touch,
		input  ready
	);
	modport sink (
		input  valid, now_us, button_a, button_b, touching, touch_x, touch_y, consume_touch,
		output ready
	);
endinterface

// one result per item
interface bctg_out_if import bctg_pkg::*; #(
	parameter int COORD_BITS = 12
) ();
	logic                         valid;
	logic                         ready;
	logic                         activity;
	logic                         go_next;
	logic                         decide;
	logic                         home;
	logic [GEST_W-1:0]            gesture;
	logic [COORD_BITS-1:0]        pos_x;
	logic [COORD_BITS-1:0]        pos_y;
	logic signed [COORD_BITS:0]   total_x;
	logic signed [COORD_BITS:0]   total_y;
	logic signed [COORD_BITS:0]   delta_x;
	logic signed [COORD_BITS:0]   delta_y;

	modport source (
		output valid, activity, go_next, decide, home, gesture, pos_x, pos_y,
		       total_x, total_y, delta_x, delta_y,
		input  ready
	);
	modport sink (
		input  valid, activity, go_next, decide, home, gesture, pos_x, pos_y,
		       total_x, total_y, delta_x, delta_y,
		output ready
	);
endinterface

// register writes
interface bctg_cfg_if import bctg_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/button_chord_touch_gesture.sv -----
// ---------------------------------------------------------------------------
// button_chord_touch_gesture
// Two-button chord detector and touch gesture classifier, one sample per item.
// ---------------------------------------------------------------------------
// Takes one sample item per clock and returns exactly one result item for it,
// valid once the sample has passed the stage 1 and result registers. The
// sample is registered, classified against the tracker state by a single
// layer of subtract/compare logic, and the result lands in an output
// register. Throughput is one item per cycle while the result side keeps
// taking items; a stall on the result side holds both stages and drops
// ready on the sample side in the same cycle. Register writes are taken at
// any time (ready is always high) but must only be issued while no item is
// in flight.
`include "button_chord_touch_gesture_macros.svh"

module button_chord_touch_gesture import bctg_pkg::*; #(
	parameter int COORD_BITS = 12,
	parameter int TIME_BITS  = 32
) (
	input logic         clk,
	input logic         arst_n,
	bctg_in_if.sink     in_item,
	bctg_out_if.source  out_item,
	bctg_cfg_if.sink    cfg
);

	localparam int SW    = COORD_BITS + 1;
	localparam int MAG_W = (SW > THR_W) ? SW : THR_W;
	localparam int CMP_W = (TIME_BITS > HOLD_W) ? TIME_BITS : HOLD_W;

	// configuration registers
	logic [THR_W-1:0]  drag_threshold_q;
	logic [HOLD_W-1:0] hold_time_us_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drag_threshold_q <= DRAG_THRESHOLD_RST;
			hold_time_us_q   <= HOLD_TIME_US_RST;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				CFG_DRAG_THRESHOLD: drag_threshold_q <= cfg.data[THR_W-1:0];
				CFG_HOLD_TIME_US:   hold_time_us_q   <= cfg.data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// both stages move together unless the result register is blocked
	logic adv;
	assign adv           = !out_item.valid || out_item.ready;
	assign in_item.ready = adv;

	// stage 1: registered sample
	logic                  v_s1;
	logic [TIME_BITS-1:0]  now_s1;
	logic                  a_s1, b_s1, t_s1, cons_s1;
	logic [COORD_BITS-1:0] x_s1, y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_item.valid) begin
			now_s1  <= in_item.now_us;
			a_s1    <= in_item.button_a;
			b_s1    <= in_item.button_b;
			t_s1    <= in_item.touching;
			cons_s1 <= in_item.consume_touch;
			x_s1    <= in_item.touch_x;
			y_s1    <= in_item.touch_y;
		end
	end

	// tracker state
	logic                  last_a_q, last_b_q, last_touching_q;
	logic [COORD_BITS-1:0] last_x_q, last_y_q;
	logic                  in_chord_q, chord_timing_q, home_fired_q;
	logic [TIME_BITS-1:0]  chord_start_us_q;
	logic [COORD_BITS-1:0] origin_x_q, origin_y_q;
	logic                  drag_active_q, touch_swallowed_q;

	// next-state and result values
	logic                  in_chord_d, chord_timing_d, home_fired_d;
	logic [TIME_BITS-1:0]  chord_start_us_d;
	logic [COORD_BITS-1:0] origin_x_d, origin_y_d;
	logic                  drag_active_d, touch_swallowed_d;

	logic                  activity_c, go_next_c, decide_c, home_c;
	gesture_t              gesture_c;
	logic [COORD_BITS-1:0] pos_x_c, pos_y_c;
	logic signed [SW-1:0]  total_x_c, total_y_c, delta_x_c, delta_y_c;

	logic [TIME_BITS-1:0]  start_eff, elapsed;
	logic                  both, none, chord_mid, touch_start, drag_mid, swal_mid;
	logic                  tracked, released, exceed;
	logic signed [SW-1:0]  trk_tx, trk_ty, trk_dx, trk_dy, rel_tx, rel_ty;
	logic [SW-1:0]         abs_tx, abs_ty;

	// displacement arithmetic
	always_comb begin
		trk_tx = $signed({1'b0, x_s1}) - $signed({1'b0, origin_x_d});
		trk_ty = $signed({1'b0, y_s1}) - $signed({1'b0, origin_y_d});
		trk_dx = $signed({1'b0, x_s1}) - $signed({1'b0, last_x_q});
		trk_dy = $signed({1'b0, y_s1}) - $signed({1'b0, last_y_q});
		rel_tx = $signed({1'b0, last_x_q}) - $signed({1'b0, origin_x_q});
		rel_ty = $signed({1'b0, last_y_q}) - $signed({1'b0, origin_y_q});
		abs_tx = trk_tx[SW-1] ? SW'(-trk_tx) : SW'(trk_tx);
		abs_ty = trk_ty[SW-1] ? SW'(-trk_ty) : SW'(trk_ty);
		exceed = (MAG_W'(abs_tx) > MAG_W'(drag_threshold_q)) ||
		         (MAG_W'(abs_ty) > MAG_W'(drag_threshold_q));
	end

	// chord timing
	always_comb begin
		both      = a_s1 && b_s1;
		none      = !a_s1 && !b_s1;
		start_eff = chord_timing_q ? chord_start_us_q : now_s1;
		elapsed   = now_s1 - start_eff;
		home_c    = both && !home_fired_q &&
		            (CMP_W'(elapsed) >= CMP_W'(hold_time_us_q));
		chord_mid = both || in_chord_q;

		chord_timing_d   = both;
		chord_start_us_d = (both && !chord_timing_q) ? now_s1 : chord_start_us_q;
		in_chord_d       = none ? 1'b0 : chord_mid;
		home_fired_d     = none ? 1'b0 : (home_fired_q || home_c);

		activity_c = a_s1 || b_s1 || t_s1 || last_a_q || last_b_q || last_touching_q;
		go_next_c  = !chord_mid && last_a_q && !a_s1 && !home_c;
		decide_c   = !chord_mid && last_b_q && !b_s1 && !home_c;
	end

	// touch tracking and gesture classification
	always_comb begin
		touch_start = t_s1 && !last_touching_q;
		origin_x_d  = touch_start ? x_s1 : origin_x_q;
		origin_y_d  = touch_start ? y_s1 : origin_y_q;
		drag_mid    = touch_start ? 1'b0 : drag_active_q;
		swal_mid    = (touch_start ? cons_s1 : touch_swallowed_q) || (cons_s1 && t_s1);
		tracked     = t_s1 && !swal_mid;
		released    = !t_s1 && last_touching_q && !swal_mid;

		gesture_c         = GEST_NONE;
		pos_x_c           = x_s1;
		pos_y_c           = y_s1;
		total_x_c         = '0;
		total_y_c         = '0;
		delta_x_c         = '0;
		delta_y_c         = '0;
		drag_active_d     = drag_mid;
		touch_swallowed_d = swal_mid;

		if (home_c) begin
			gesture_c         = GEST_CANCEL;
			touch_swallowed_d = t_s1;
			drag_active_d     = 1'b0;
		end else if (tracked) begin
			total_x_c = trk_tx;
			total_y_c = trk_ty;
			delta_x_c = trk_dx;
			delta_y_c = trk_dy;
			if (!drag_mid && exceed) begin
				drag_active_d = 1'b1;
				gesture_c     = GEST_DRAG_START;
			end else if (drag_mid && (trk_dx != '0 || trk_dy != '0)) begin
				gesture_c = GEST_DRAG_MOVE;
			end
		end else if (released) begin
			pos_x_c   = last_x_q;
			pos_y_c   = last_y_q;
			total_x_c = rel_tx;
			total_y_c = rel_ty;
			gesture_c = drag_mid ? GEST_DRAG_END : GEST_TAP;
		end

		// no touch ends all tracking
		if (!t_s1) begin
			touch_swallowed_d = 1'b0;
			drag_active_d     = 1'b0;
		end
	end

	// state update on each classified item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_a_q          <= 1'b0;
			last_b_q          <= 1'b0;
			last_touching_q   <= 1'b0;
			last_x_q          <= '0;
			last_y_q          <= '0;
			in_chord_q        <= 1'b0;
			chord_timing_q    <= 1'b0;
			home_fired_q      <= 1'b0;
			chord_start_us_q  <= '0;
			origin_x_q        <= '0;
			origin_y_q        <= '0;
			drag_active_q     <= 1'b0;
			touch_swallowed_q <= 1'b0;
		end else if (adv && v_s1) begin
			last_a_q          <= a_s1;
			last_b_q          <= b_s1;
			last_touching_q   <= t_s1;
			last_x_q          <= x_s1;
			last_y_q          <= y_s1;
			in_chord_q        <= in_chord_d;
			chord_timing_q    <= chord_timing_d;
			home_fired_q      <= home_fired_d;
			chord_start_us_q  <= chord_start_us_d;
			origin_x_q        <= origin_x_d;
			origin_y_q        <= origin_y_d;
			drag_active_q     <= drag_active_d;
			touch_swallowed_q <= touch_swallowed_d;
		end
	end

	// stage 2: result register
	logic v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			out_item.activity <= activity_c;
			out_item.go_next  <= go_next_c;
			out_item.decide   <= decide_c;
			out_item.home     <= home_c;
			out_item.gesture  <= gesture_c;
			out_item.pos_x    <= pos_x_c;
			out_item.pos_y    <= pos_y_c;
			out_item.total_x  <= total_x_c;
			out_item.total_y  <= total_y_c;
			out_item.delta_x  <= delta_x_c;
			out_item.delta_y  <= delta_y_c;
		end
	end

	assign out_item.valid = v_s2;

	// home always cancels and silences the button events
	`BCTG_ASSERT_IMPLY(a_home_cancels, v_s2 && out_item.home,
		out_item.gesture == GEST_CANCEL && !out_item.go_next && !out_item.decide)
	// a release report carries no per-sample change
	`BCTG_ASSERT_IMPLY(a_release_no_delta,
		v_s2 && (out_item.gesture == GEST_DRAG_END || out_item.gesture == GEST_TAP),
		out_item.delta_x == '0 && out_item.delta_y == '0)
	// drag and swallow flags only live while a touch is held
	`BCTG_ASSERT_IMPLY(a_drag_needs_touch, drag_active_q || touch_swallowed_q, last_touching_q)
	// home fires at most once per chord
	`BCTG_ASSERT_NEXT(a_home_once, adv && v_s1 && home_c,
		!home_c || !(a_s1 && b_s1) || !v_s1)

endmodule

// ----- tb/tb_button_chord_touch_gesture.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_button_chord_touch_gesture
// Self-checking bench for the button chord and touch gesture tracker.
// A driver feeds sample items and register writes from a queue of host
// operations. A predictor tracks chord and touch state and works out the
// report for every accepted sample. A monitor compares each result item
// field by field. Both sides idle at random, the result side holds off once
// for a long stretch, and register writes happen only with nothing in flight.
// ---------------------------------------------------------------------------
module tb_button_chord_touch_gesture;
	import bctg_pkg::*;

	localparam int SETTLE_CYCLES = 4;        // output latency plus margin
	localparam int CALM_LO       = 450;      // no-idle stretch, in items
	localparam int CALM_HI       = 650;
	localparam int HOLDOFF_AT    = 500;      // result count that starts the holdoff
	localparam int HOLDOFF_LEN   = 60;
	localparam int LIMIT_NS      = 2000000;

	typedef struct packed {
		logic [31:0] now_us;
		logic        btn_a;
		logic        btn_b;
		logic        touching;
		logic [11:0] x;
		logic [11:0] y;
		logic        consume;
	} sample_t;

	typedef struct packed {
		logic        activity;
		logic        go_next;
		logic        decide;
		logic        home;
		gesture_t    gesture;
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic [12:0] total_x;
		logic [12:0] total_y;
		logic [12:0] delta_x;
		logic [12:0] delta_y;
	} report_t;

	typedef enum logic [1:0] {
		OP_SAMPLE,
		OP_WRITE,
		OP_DRAIN
	} op_kind_t;

	typedef struct {
		op_kind_t    kind;
		sample_t     smp;
		cfg_idx_t    reg_idx;
		logic [31:0] reg_val;
	} host_op_t;

	logic clk = 1'b0;
	logic arst_n;

	bctg_in_if  #(.COORD_BITS(12), .TIME_BITS(32)) in_ch ();
	bctg_out_if #(.COORD_BITS(12))                 out_ch ();
	bctg_cfg_if                                    cfg_ch ();

	button_chord_touch_gesture #(
		.COORD_BITS(12),
		.TIME_BITS (32)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_item (in_ch),
		.out_item(out_ch),
		.cfg     (cfg_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	host_op_t host_ops[$];
	report_t  gesture_reports[$];
	int       n_errors = 0;
	int       n_sent;
	int       n_results;
	int       quiet;
	int       holdoff_cnt;
	bit       holdoff_done;
	bit       offer_smp;
	bit       offer_cfg;
	bit       settled;

	// tracker copy: registers and state, reset values
	logic [11:0] thr_cfg  = DRAG_THRESHOLD_RST;
	logic [31:0] hold_cfg = HOLD_TIME_US_RST;
	bit          prv_a = 0, prv_b = 0, prv_touch = 0;
	logic [11:0] prv_x = '0, prv_y = '0;
	bit          chord_on = 0, chord_armed = 0, home_done = 0;
	logic [31:0] chord_t0 = '0;
	logic [11:0] org_x = '0, org_y = '0;
	bit          dragging = 0, swallowed = 0;

	// stimulus generator state
	logic [31:0] gen_now;
	bit          gen_a, gen_b, gen_t;
	int          gen_x, gen_y;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at result %0d: %s", n_results, msg);
		n_errors++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	function automatic int mag(input int v);
		return (v < 0) ? -v : v;
	endfunction

	// work out the report for one sample and advance the tracker
	task automatic classify_sample(input sample_t s);
		report_t     r;
		logic [31:0] elapsed;
		int          tx, ty, dx, dy;
		r = '0;
		r.gesture = GEST_NONE;
		r.activity = s.btn_a | s.btn_b | s.touching | prv_a | prv_b | prv_touch;
		r.pos_x = s.x;
		r.pos_y = s.y;

		// two-button chord timing, elapsed time wraps at 32 bits
		if (s.btn_a && s.btn_b) begin
			chord_on = 1;
			if (!chord_armed) begin
				chord_armed = 1;
				chord_t0 = s.now_us;
			end
			elapsed = s.now_us - chord_t0;
			if (!home_done && elapsed >= hold_cfg) begin
				r.home = 1'b1;
				home_done = 1;
			end
		end else begin
			chord_armed = 0;
		end
		if (!chord_on) begin
			r.go_next = prv_a & ~s.btn_a;
			r.decide = prv_b & ~s.btn_b;
		end
		if (!s.btn_a && !s.btn_b) begin
			chord_on = 0;
			home_done = 0;
		end

		// touch start and claim
		if (s.touching && !prv_touch) begin
			org_x = s.x;
			org_y = s.y;
			dragging = 0;
			swallowed = s.consume;
		end
		if (s.consume && s.touching)
			swallowed = 1;

		if (r.home) begin
			// home cancels the gesture and swallows a held touch
			r.go_next = 1'b0;
			r.decide = 1'b0;
			r.gesture = GEST_CANCEL;
			swallowed = s.touching;
			dragging = 0;
		end else if (s.touching && !swallowed) begin
			tx = int'(s.x) - int'(org_x);
			ty = int'(s.y) - int'(org_y);
			dx = int'(s.x) - int'(prv_x);
			dy = int'(s.y) - int'(prv_y);
			r.total_x = tx[12:0];
			r.total_y = ty[12:0];
			r.delta_x = dx[12:0];
			r.delta_y = dy[12:0];
			if (!dragging && (mag(tx) > int'(thr_cfg) || mag(ty) > int'(thr_cfg))) begin
				dragging = 1;
				r.gesture = GEST_DRAG_START;
			end else if (dragging && (dx != 0 || dy != 0)) begin
				r.gesture = GEST_DRAG_MOVE;
			end
		end else if (!s.touching && prv_touch && !swallowed) begin
			// release reports the last touched point
			tx = int'(prv_x) - int'(org_x);
			ty = int'(prv_y) - int'(org_y);
			r.pos_x = prv_x;
			r.pos_y = prv_y;
			r.total_x = tx[12:0];
			r.total_y = ty[12:0];
			r.gesture = dragging ? GEST_DRAG_END : GEST_TAP;
		end
		if (!s.touching) begin
			swallowed = 0;
			dragging = 0;
		end

		prv_a = s.btn_a;
		prv_b = s.btn_b;
		prv_touch = s.touching;
		prv_x = s.x;
		prv_y = s.y;
		gesture_reports.push_back(r);
	endtask

	task automatic apply_write(input cfg_idx_t idx, input logic [31:0] val);
		case (idx)
			CFG_DRAG_THRESHOLD: thr_cfg = val[11:0];
			CFG_HOLD_TIME_US:   hold_cfg = val;
			default: ;
		endcase
	endtask

	task automatic check_report(input report_t w);
		check_field("activity", out_ch.activity, w.activity);
		check_field("go_next", out_ch.go_next, w.go_next);
		check_field("decide", out_ch.decide, w.decide);
		check_field("home", out_ch.home, w.home);
		check_field("gesture", out_ch.gesture, w.gesture);
		check_field("pos_x", out_ch.pos_x, w.pos_x);
		check_field("pos_y", out_ch.pos_y, w.pos_y);
		check_field("total_x", {out_ch.total_x}, w.total_x);
		check_field("total_y", {out_ch.total_y}, w.total_y);
		check_field("delta_x", {out_ch.delta_x}, w.delta_x);
		check_field("delta_y", {out_ch.delta_y}, w.delta_y);
	endtask

	// ---- host operation builders ----
	task automatic push_sample(input logic [31:0] now, input bit a, input bit b,
			input bit t, input int x, input int y, input bit c);
		host_op_t op;
		op.kind = OP_SAMPLE;
		op.smp = '{now, a, b, t, x[11:0], y[11:0], c};
		op.reg_idx = CFG_DRAG_THRESHOLD;
		op.reg_val = '0;
		host_ops.push_back(op);
	endtask

	// wait for every report, then write both registers
	task automatic set_config(input logic [11:0] thr, input logic [31:0] hold);
		host_op_t op;
		op.smp = '0;
		op.reg_val = '0;
		op.reg_idx = CFG_DRAG_THRESHOLD;
		op.kind = OP_DRAIN;
		host_ops.push_back(op);
		op.kind = OP_WRITE;
		op.reg_val = {20'd0, thr};
		host_ops.push_back(op);
		op.reg_idx = CFG_HOLD_TIME_US;
		op.reg_val = hold;
		host_ops.push_back(op);
	endtask

	function automatic int wander(input int v);
		int r;
		int nv;
		r = $urandom_range(99);
		if (r < 30)
			return v;
		if (r < 85) begin
			nv = v + int'($urandom_range(40)) - 20;
			if (nv < 0)
				nv = 0;
			if (nv > 4095)
				nv = 4095;
			return nv;
		end
		return $urandom_range(4095);
	endfunction

	// random button and touch sessions with some pure noise mixed in
	task automatic random_phase(input int n_items, input logic [31:0] step_max);
		int k;
		bit consume;
		gen_now = $urandom;
		for (k = 0; k < n_items; k++) begin
			if ($urandom_range(99) < 8) begin
				push_sample($urandom, $urandom_range(1), $urandom_range(1),
					$urandom_range(1), $urandom_range(4095), $urandom_range(4095),
					$urandom_range(1));
			end else begin
				consume = 0;
				if ($urandom_range(99) < 15)
					gen_a = !gen_a;
				if ($urandom_range(99) < 15)
					gen_b = !gen_b;
				if ($urandom_range(99) < 15) begin
					gen_t = !gen_t;
					if (gen_t) begin
						gen_x = $urandom_range(4095);
						gen_y = $urandom_range(4095);
						consume = $urandom_range(99) < 15;
					end
				end else if (gen_t) begin
					gen_x = wander(gen_x);
					gen_y = wander(gen_y);
					consume = $urandom_range(99) < 4;
				end else if ($urandom_range(99) < 30) begin
					gen_x = $urandom_range(4095);
					gen_y = $urandom_range(4095);
				end
				gen_now = gen_now + $urandom_range(step_max);
				push_sample(gen_now, gen_a, gen_b, gen_t, gen_x, gen_y, consume);
			end
		end
	endtask

	// ---- driver: samples and register writes from the host queue ----
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.now_us <= '0;
			in_ch.button_a <= 1'b0;
			in_ch.button_b <= 1'b0;
			in_ch.touching <= 1'b0;
			in_ch.touch_x <= '0;
			in_ch.touch_y <= '0;
			in_ch.consume_touch <= 1'b0;
			cfg_ch.valid <= 1'b0;
			cfg_ch.index <= CFG_DRAG_THRESHOLD;
			cfg_ch.data <= '0;
			n_sent <= 0;
			quiet <= 0;
		end else begin
			// retire what was taken at this edge
			if (in_ch.valid && in_ch.ready) begin
				classify_sample(host_ops[0].smp);
				host_ops.delete(0);
				n_sent <= n_sent + 1;
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				apply_write(host_ops[0].reg_idx, host_ops[0].reg_val);
				host_ops.delete(0);
			end

			settled = quiet >= SETTLE_CYCLES && gesture_reports.size() == 0 && !in_ch.valid;
			offer_smp = 0;
			offer_cfg = 0;
			if (in_ch.valid && !in_ch.ready) begin
				offer_smp = 1;
			end else if (cfg_ch.valid && !cfg_ch.ready) begin
				offer_cfg = 1;
			end else if (host_ops.size() != 0) begin
				case (host_ops[0].kind)
					OP_SAMPLE: begin
						offer_smp = (n_sent >= CALM_LO && n_sent < CALM_HI) ||
							$urandom_range(99) >= 26;
					end
					OP_WRITE: offer_cfg = settled;
					default: begin
						if (settled)
							host_ops.delete(0);
					end
				endcase
			end

			in_ch.valid <= offer_smp;
			if (offer_smp) begin
				in_ch.now_us <= host_ops[0].smp.now_us;
				in_ch.button_a <= host_ops[0].smp.btn_a;
				in_ch.button_b <= host_ops[0].smp.btn_b;
				in_ch.touching <= host_ops[0].smp.touching;
				in_ch.touch_x <= host_ops[0].smp.x;
				in_ch.touch_y <= host_ops[0].smp.y;
				in_ch.consume_touch <= host_ops[0].smp.consume;
			end
			cfg_ch.valid <= offer_cfg;
			if (offer_cfg) begin
				cfg_ch.index <= host_ops[0].reg_idx;
				cfg_ch.data <= host_ops[0].reg_val;
			end

			// idle cycles with nothing in flight
			quiet <= (gesture_reports.size() == 0 && !in_ch.valid) ? quiet + 1 : 0;
		end
	end

	// ---- result side holdoff, once, long enough to back up the input ----
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_cnt <= 0;
			holdoff_done <= 1'b0;
		end else if (!holdoff_done && n_results >= HOLDOFF_AT) begin
			holdoff_cnt <= HOLDOFF_LEN;
			holdoff_done <= 1'b1;
		end else if (holdoff_cnt != 0) begin
			holdoff_cnt <= holdoff_cnt - 1;
		end
	end

	// ---- monitor: compare each result item with the oldest report ----
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			n_results <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				n_results <= n_results + 1;
				if (gesture_reports.size() == 0) begin
					report_mismatch("result item with no report waiting");
				end else begin
					check_report(gesture_reports[0]);
					gesture_reports.delete(0);
				end
			end
			out_ch.ready <= holdoff_cnt == 0 &&
				((n_results >= CALM_LO && n_results < CALM_HI) || $urandom_range(99) >= 26);
		end
	end

	// ---- stimulus, reset and end of run ----
	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.now_us = '0;
		in_ch.button_a = 1'b0;
		in_ch.button_b = 1'b0;
		in_ch.touching = 1'b0;
		in_ch.touch_x = '0;
		in_ch.touch_y = '0;
		in_ch.consume_touch = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_DRAG_THRESHOLD;
		cfg_ch.data = '0;
		out_ch.ready = 1'b0;
		gen_a = 0;
		gen_b = 0;
		gen_t = 0;
		gen_x = 0;
		gen_y = 0;

		// lone press and release of each button
		push_sample(0, 0, 0, 0, 0, 0, 0);
		push_sample(1000, 1, 0, 0, 0, 0, 0);
		push_sample(2000, 0, 0, 0, 0, 0, 0);
		push_sample(3000, 0, 1, 0, 4095, 4095, 0);
		push_sample(4000, 0, 0, 0, 4095, 4095, 0);
		// chord across the timestamp wrap, home at exactly the hold time,
		// then a silent release one button at a time
		push_sample(32'hFFFF_0000, 1, 1, 0, 10, 10, 0);
		push_sample(32'hFFFF_0000 + 32'd300000, 1, 1, 0, 10, 10, 0);
		push_sample(32'hFFFF_0000 + 32'd600000, 1, 1, 0, 10, 10, 0);
		push_sample(32'hFFFF_0000 + 32'd700000, 1, 1, 0, 10, 10, 0);
		push_sample(32'hFFFF_0000 + 32'd800000, 0, 1, 0, 10, 10, 0);
		push_sample(32'hFFFF_0000 + 32'd900000, 0, 0, 0, 10, 10, 0);
		// small wiggle then release: tap
		push_sample(10000, 0, 0, 1, 100, 100, 0);
		push_sample(11000, 0, 0, 1, 103, 95, 0);
		push_sample(12000, 0, 0, 0, 0, 0, 0);
		// corner to corner drag, a move, a stationary sample, drag end
		push_sample(13000, 0, 0, 1, 0, 0, 0);
		push_sample(14000, 0, 0, 1, 4095, 4095, 0);
		push_sample(15000, 0, 0, 1, 0, 4095, 0);
		push_sample(16000, 0, 0, 1, 0, 4095, 0);
		push_sample(17000, 0, 0, 0, 0, 4095, 0);
		// claimed touch stays silent through its release
		push_sample(18000, 0, 0, 1, 500, 500, 1);
		push_sample(19000, 0, 0, 1, 900, 900, 0);
		push_sample(20000, 0, 0, 0, 900, 900, 0);
		// home while touching swallows the touch until release
		push_sample(21000, 1, 1, 1, 2000, 2000, 0);
		push_sample(621000, 1, 1, 1, 2100, 2100, 0);
		push_sample(622000, 1, 1, 1, 2300, 2300, 0);
		push_sample(623000, 0, 0, 0, 2300, 2300, 0);

		random_phase(200, 200000);

		// zero hold time fires on the first chord sample; zero threshold
		set_config(12'd0, 32'd0);
		push_sample(700000, 0, 0, 0, 50, 50, 0);
		push_sample(700100, 1, 1, 0, 50, 50, 0);
		push_sample(700200, 0, 0, 1, 50, 50, 0);
		push_sample(700300, 0, 0, 1, 51, 50, 0);
		random_phase(150, 5000);

		set_config(12'($urandom_range(1, 60)), 32'd50000);
		random_phase(350, 20000);

		set_config(12'd4095, 32'hFFFF_FFFF);
		random_phase(150, 32'h3FFF_FFFF);

		set_config(DRAG_THRESHOLD_RST, HOLD_TIME_US_RST);
		random_phase(100, 200000);

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (host_ops.size() != 0 || gesture_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES * 4) @(posedge clk);
		if (n_errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(LIMIT_NS);
		$display("TEST FAILED");
		$finish;
	end

endmodule
